// ===== design/xce_pkg.sv =====
// ----------------------------------------------------------------------------
// XML escape encoder package
// Shared types, character codes and encoding functions for the encoder.
// ----------------------------------------------------------------------------
package xce_pkg;

  localparam int unsigned SEQ_MAX = 7;

  typedef logic [7:0] char_t;
  typedef logic [2:0] seq_len_t;

  typedef enum logic [1:0] {
    MODE_ATTR = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef struct packed {
    char_t [SEQ_MAX-1:0] chars;
    seq_len_t            len;
    logic                last;
  } job_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_BKSP   = 8'h08;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_VT     = 8'h0B;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SO     = 8'h0E;
  localparam char_t CH_US     = 8'h1F;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_HASH   = 8'h23;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_APOS   = 8'h27;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_LC_A   = 8'h61;
  localparam char_t CH_LC_B   = 8'h62;
  localparam char_t CH_LC_F   = 8'h66;
  localparam char_t CH_LC_G   = 8'h67;
  localparam char_t CH_LC_L   = 8'h6C;
  localparam char_t CH_LC_M   = 8'h6D;
  localparam char_t CH_LC_N   = 8'h6E;
  localparam char_t CH_LC_O   = 8'h6F;
  localparam char_t CH_LC_P   = 8'h70;
  localparam char_t CH_LC_Q   = 8'h71;
  localparam char_t CH_LC_R   = 8'h72;
  localparam char_t CH_LC_S   = 8'h73;
  localparam char_t CH_LC_T   = 8'h74;
  localparam char_t CH_LC_U   = 8'h75;
  localparam char_t CH_DEL    = 8'h7F;

  function automatic job_t put(input job_t j, input char_t ch);
    job_t r;
    r = j;
    r.chars[r.len] = ch;
    r.len = r.len + 3'd1;
    return r;
  endfunction

  function automatic job_t put_quot(input job_t j);
    job_t r;
    r = put(j, CH_AMP);
    r = put(r, CH_LC_Q);
    r = put(r, CH_LC_U);
    r = put(r, CH_LC_O);
    r = put(r, CH_LC_T);
    r = put(r, CH_SEMI);
    return r;
  endfunction

  function automatic job_t put_squot(input job_t j);
    job_t r;
    r = put(j, CH_AMP);
    r = put(r, CH_LC_S);
    r = put(r, CH_LC_Q);
    r = put(r, CH_LC_U);
    r = put(r, CH_LC_O);
    r = put(r, CH_LC_T);
    r = put(r, CH_SEMI);
    return r;
  endfunction

  // Decimal reference with no leading zeros. Tens come from a multiply by
  // the reciprocal of ten, exact for remainders below one hundred.
  function automatic job_t put_ref(input job_t j, input char_t v);
    logic [1:0]  hund;
    char_t       rem;
    logic [15:0] prod;
    logic [3:0]  tens;
    char_t       ones;
    job_t        r;
    hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - 8'(8'(hund) * 8'd100);
    prod = 16'(rem) * 16'd205;
    tens = prod[14:11];
    ones = rem - 8'(8'(tens) * 8'd10);
    r = put(j, CH_AMP);
    r = put(r, CH_HASH);
    if (v >= 8'd100) begin
      r = put(r, CH_ZERO + 8'(hund));
    end
    if (v >= 8'd10) begin
      r = put(r, CH_ZERO + 8'(tens));
    end
    r = put(r, CH_ZERO + ones);
    r = put(r, CH_SEMI);
    return r;
  endfunction

  function automatic logic needs_ref(input char_t c);
    return (c <= CH_BKSP) || (c == CH_VT) || (c == CH_FF) ||
           ((c >= CH_SO) && (c <= CH_US)) || (c >= CH_DEL);
  endfunction

  function automatic job_t put_encoded(input job_t j, input char_t c);
    job_t r;
    r = j;
    if (c == CH_NUL) begin
      r = put(r, CH_SPACE);
    end else if (needs_ref(c)) begin
      r = put_ref(r, c);
    end else if (c == CH_QUOTE) begin
      r = put_quot(r);
    end else if (c == CH_AMP) begin
      r = put(r, CH_AMP);
      r = put(r, CH_LC_A);
      r = put(r, CH_LC_M);
      r = put(r, CH_LC_P);
      r = put(r, CH_SEMI);
    end else if (c == CH_LT) begin
      r = put(r, CH_AMP);
      r = put(r, CH_LC_L);
      r = put(r, CH_LC_T);
      r = put(r, CH_SEMI);
    end else if (c == CH_GT) begin
      r = put(r, CH_AMP);
      r = put(r, CH_LC_G);
      r = put(r, CH_LC_T);
      r = put(r, CH_SEMI);
    end else begin
      r = put(r, c);
    end
    return r;
  endfunction

endpackage

// ===== design/xce_front.sv =====
// ----------------------------------------------------------------------------
// XML escape encoder front end
// Holds the mode register and the held-backslash flag, and turns each
// accepted input byte into a job listing the output bytes it produces.
// ----------------------------------------------------------------------------
module xce_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_wr_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_string_end,
  input  logic           q_full,
  output logic           q_push,
  output xce_pkg::job_t  q_job
);
  import xce_pkg::*;

  mode_t mode_r;
  logic  pending_r;
  logic  pending_nxt;
  logic  accept;
  job_t  job;

  always_comb begin
    job         = '0;
    pending_nxt = pending_r;
    case (mode_r)
      MODE_ESC: begin
        if (pending_r) begin
          pending_nxt = 1'b0;
          case (in_byte)
            CH_BSLASH: job = put(job, CH_BSLASH);
            CH_QUOTE:  job = put_quot(job);
            CH_APOS:   job = put_squot(job);
            CH_LC_B:   job = put(job, CH_BKSP);
            CH_LC_F:   job = put(job, CH_FF);
            CH_LC_N:   job = put(job, CH_LF);
            CH_LC_R:   job = put(job, CH_CR);
            CH_LC_T:   job = put(job, CH_TAB);
            default:   job = put_encoded(put(job, CH_BSLASH), in_byte);
          endcase
        end else if (in_byte == CH_BSLASH) begin
          pending_nxt = 1'b1;
          if (in_string_end) begin
            job = put(job, CH_BSLASH);
          end
        end else begin
          job = put_encoded(job, in_byte);
        end
      end
      MODE_BODY: begin
        pending_nxt = 1'b0;
        if ((in_byte == CH_QUOTE) || (in_byte == CH_APOS)) begin
          job = put(job, in_byte);
        end else begin
          job = put_encoded(job, in_byte);
        end
      end
      default: begin
        pending_nxt = 1'b0;
        job = put_encoded(job, in_byte);
      end
    endcase
    if (in_string_end) begin
      pending_nxt = 1'b0;
    end
    job.last = in_string_end;
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (job.len != '0);
  assign q_job    = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ATTR;
      pending_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= mode_t'(cfg_wr_data);
      end
      if (accept) begin
        pending_r <= pending_nxt;
      end
    end
  end

endmodule

// ===== design/xce_queue.sv =====
// ----------------------------------------------------------------------------
// XML escape encoder job queue
// A short first-in first-out queue of jobs between front and back end.
// ----------------------------------------------------------------------------
module xce_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xce_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output xce_pkg::job_t  head
);
  import xce_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/xce_back.sv =====
// ----------------------------------------------------------------------------
// XML escape encoder back end
// Takes jobs from the queue and sends their bytes out one per transfer.
// ----------------------------------------------------------------------------
module xce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  xce_pkg::job_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_text_end
);
  import xce_pkg::*;

  logic     busy_r;
  job_t     job_r;
  seq_len_t idx_r;
  logic     fire;
  logic     at_end;
  logic     load;

  assign fire   = busy_r && !out_stall;
  assign at_end = (idx_r == (job_r.len - 3'd1));
  assign load   = !q_empty && (!busy_r || (fire && at_end));
  assign q_pop  = load;

  assign out_valid    = busy_r;
  assign out_byte     = job_r.chars[idx_r];
  assign out_run_last = at_end;
  assign out_text_end = at_end && job_r.last;

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

// ===== design/xml_char_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// XML escape encoder, top level
// Encodes an ISO 8859-1 byte stream into XML-escaped text. The output side
// sends one byte per cycle while out_stall is low. An input byte is taken
// every cycle while the job queue (QUEUE_DEPTH entries) has room; a byte
// expands to at most 7 output bytes, sent one by one, so the input rate is
// set by the total output length. A held backslash in escape mode produces
// no output until the next byte or the end of the string. The user must
// write the mode register only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module xml_char_escape_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import xce_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  xce_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  xce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  xce_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("Job pushed into a full queue.");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_job.len != '0))
    else $error("Queued job carries no output bytes.");

  a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_end) |-> out_run_last)
    else $error("End of text flagged before the last byte of its run.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");
`endif

endmodule
